FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/nnps_pkg.sv
// shared types, constants and helper function for the scaler
package nnps_pkg;

  localparam int SOURCE_PIXELS = 4096;
  localparam int MAX_DST_WIDTH = 64;
  localparam int FRAC_BITS     = 10;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int DSTW_W    = 7;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 6;
  localparam int PIX_IDX_W = 12;
  localparam int CH_W      = 8;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  // shared divider operand widths
  localparam int DVD_W = 25;
  localparam int DVS_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 3'd4;

  // input kinds carried in tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last;
  } meta_t;

  // floor(x / 255), exact for any product of two bytes
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

FILE: src/nnps_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module nnps_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nnps_pkg::DVD_W-1:0] dividend,
  input  logic [nnps_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [nnps_pkg::DVD_W-1:0] quotient
);

  localparam int DVD_W = nnps_pkg::DVD_W;
  localparam int DVS_W = nnps_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;

  logic [DVS_W:0]   rem_shift;
  logic             ge;
  logic [DVS_W-1:0] rem_next;

  // remainder stays below the divisor, so DVS_W bits hold it
  assign rem_shift = {rem, quo[DVD_W-1]};
  assign ge        = rem_shift >= {1'b0, dvs};
  assign rem_next  = ge ? DVS_W'(rem_shift - {1'b0, dvs}) : rem_shift[DVS_W-1:0];
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= rem_next;
    end
  end

endmodule

FILE: src/nnps_src_mem.sv
// source pixel memory, one write port and one registered read port
module nnps_src_mem #(
  parameter int SOURCE_PIXELS = nnps_pkg::SOURCE_PIXELS
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(SOURCE_PIXELS)-1:0] waddr,
  input  logic [31:0]                      wdata,
  input  logic                             re,
  input  logic [$clog2(SOURCE_PIXELS)-1:0] raddr,
  output logic [31:0]                      rdata
);

  logic [31:0] mem [SOURCE_PIXELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/nnps_premul.sv
// alpha premultiply stage and output register of the pixel stream
module nnps_premul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     pix,
  input  nnps_pkg::meta_t                 meta,
  output logic                            tvalid,
  input  logic                            tready,
  output logic [nnps_pkg::OUT_DATA_W-1:0] tdata,
  output logic                            tlast
);

  logic            v2;
  logic [15:0]     p0;
  logic [15:0]     p1;
  logic [15:0]     p2;
  nnps_pkg::meta_t meta2;

  logic                      v3;
  logic [nnps_pkg::CH_W-1:0] o0;
  logic [nnps_pkg::CH_W-1:0] o1;
  logic [nnps_pkg::CH_W-1:0] o2;
  nnps_pkg::meta_t           meta3;

  logic adv3;

  assign adv3     = !v3 || tready;
  assign in_ready = !v2 || adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (in_ready) begin
        v2 <= in_valid;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p0    <= pix[7:0]   * pix[31:24];
      p1    <= pix[15:8]  * pix[31:24];
      p2    <= pix[23:16] * pix[31:24];
      meta2 <= meta;
    end
    if (adv3 && v2) begin
      o0    <= nnps_pkg::div255(p0);
      o1    <= nnps_pkg::div255(p1);
      o2    <= nnps_pkg::div255(p2);
      meta3 <= meta2;
    end
  end

  assign tvalid = v3;
  assign tlast  = meta3.last;
  assign tdata  = {6'd0, meta3.row, meta3.column, o2, o1, o0};

endmodule

FILE: src/nearest_neighbour_premultiply_scaler_top.sv
// Nearest-neighbour RGBA scaler with alpha premultiplication.
// Input stream (s_axis): tuser selects the kind. A load transaction writes one
// 32-bit source pixel at pixel_index; loads may follow each other in every
// cycle. A render transaction names one destination row; if the row is below
// rows_in_use and dst_width is nonzero, the block emits min(dst_width, 64)
// premultiplied pixels on m_axis, left to right, tlast on the final one.
// Other renders produce nothing.
// A render computes its source row and column step on a bit-serial divider
// (two divisions of 25 quotient bits each), then reads the source memory once
// per pixel at one pixel per cycle while the premultiply stage accepts. Input
// is blocked from acceptance until the last read of the row is issued. The
// first pixel appears after both divisions, the memory read, the premultiply
// register and the output register.
// A stall on m_axis holds the output register, then the premultiply stage,
// then the memory read; no pixel is lost or repeated. Reset (rst, synchronous)
// clears the control state and sets the config registers to their defaults;
// the source memory is not cleared and must be loaded before it is rendered.
// The user must make config writes only while idle; the block does not enforce it.
module nearest_neighbour_premultiply_scaler_top #(
  parameter int SOURCE_PIXELS = nnps_pkg::SOURCE_PIXELS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_index[11:0], in_c0[19:12], in_c1[27:20], in_c2[35:28],
  // in_alpha[43:36], row[55:44]
  input  logic [nnps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_c0[7:0], out_c1[15:8], out_c2[23:16], out_column[29:24],
  // out_row[41:30], zero[47:42]
  output logic [nnps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [nnps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnps_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW     = $clog2(SOURCE_PIXELS);
  localparam int ACC_W  = AW + nnps_pkg::FRAC_BITS;
  localparam int PW     = (AW > nnps_pkg::PIX_IDX_W) ? AW : nnps_pkg::PIX_IDX_W;
  localparam int CFG_W  = nnps_pkg::CFG_W;
  localparam int DSTW_W = nnps_pkg::DSTW_W;
  localparam int ROW_W  = nnps_pkg::ROW_W;
  localparam int DVD_W  = nnps_pkg::DVD_W;
  localparam int DVS_W  = nnps_pkg::DVS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DROW  = 2'd1;
  localparam logic [1:0] S_DSTEP = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  logic [CFG_W-1:0]  src_width;
  logic [CFG_W-1:0]  src_height;
  logic [DSTW_W-1:0] dst_width;
  logic [CFG_W-1:0]  dst_height;
  logic [CFG_W-1:0]  rows_in_use;

  logic [1:0]        state;
  logic [ROW_W-1:0]  row;
  logic [AW-1:0]     base;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  step;
  logic [DSTW_W-1:0] x;

  logic                 s_accept;
  logic                 is_render;
  logic [nnps_pkg::PIX_IDX_W-1:0] in_pix_index;
  logic [ROW_W-1:0]     in_row;
  logic [PW-1:0]        pix_ext;

  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [AW-1:0]    src_row_lo;
  logic [AW+CFG_W-1:0] base_prod;

  logic [DSTW_W-1:0] count_lim;
  logic              last_px;
  logic              v1;
  logic              p_ready;
  logic              adv1;
  logic              issue;
  logic [AW-1:0]     raddr;
  logic [31:0]       rdata;
  nnps_pkg::meta_t   meta1;

  assign in_pix_index = s_axis_tdata[11:0];
  assign in_row       = s_axis_tdata[55:44];
  assign pix_ext      = PW'(in_pix_index);

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign is_render     = s_accept && (s_axis_tuser == nnps_pkg::OP_RENDER)
                         && ({1'b0, in_row} < rows_in_use) && (dst_width != '0);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= CFG_W'(1);
      src_height  <= CFG_W'(1);
      dst_width   <= DSTW_W'(1);
      dst_height  <= CFG_W'(1);
      rows_in_use <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nnps_pkg::REG_SRC_WIDTH:   src_width   <= cfg_data;
        nnps_pkg::REG_SRC_HEIGHT:  src_height  <= cfg_data;
        nnps_pkg::REG_DST_WIDTH:   dst_width   <= cfg_data[DSTW_W-1:0];
        nnps_pkg::REG_DST_HEIGHT:  dst_height  <= cfg_data;
        nnps_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // divider operands: source row first, then the column step
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVD_W'(in_row) * DVD_W'(src_height);
    div_divisor  = dst_height;
    if (state == S_IDLE) begin
      div_start = is_render;
    end else if (state == S_DROW) begin
      div_start    = div_done;
      div_dividend = DVD_W'({src_width, {nnps_pkg::FRAC_BITS{1'b0}}});
      div_divisor  = DVS_W'(dst_width);
    end
  end

  nnps_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // zero dst_height maps every row to source row 0
  assign src_row_lo = (dst_height == '0) ? '0 : div_quo[AW-1:0];
  assign base_prod  = src_row_lo * src_width;

  assign count_lim = (dst_width > DSTW_W'(nnps_pkg::MAX_DST_WIDTH))
                     ? DSTW_W'(nnps_pkg::MAX_DST_WIDTH) : dst_width;
  assign last_px   = (DSTW_W'(x + DSTW_W'(1)) == count_lim);

  assign adv1  = !v1 || p_ready;
  assign issue = (state == S_RUN) && adv1;
  assign raddr = base + acc[ACC_W-1:nnps_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      v1    <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= issue;
      end
      case (state)
        S_IDLE: begin
          if (is_render) begin
            state <= S_DROW;
          end
        end
        S_DROW: begin
          if (div_done) begin
            state <= S_DSTEP;
          end
        end
        S_DSTEP: begin
          if (div_done) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (issue && last_px) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_render && state == S_IDLE) begin
      row <= in_row;
    end
    if (state == S_DROW && div_done) begin
      base <= base_prod[AW-1:0];
    end
    if (state == S_DSTEP && div_done) begin
      step <= ACC_W'(div_quo);
      acc  <= ACC_W'(div_quo >> nnps_pkg::FRAC_BITS);
      x    <= '0;
    end else if (issue) begin
      acc          <= acc + step;
      x            <= x + DSTW_W'(1);
      meta1.column <= x[nnps_pkg::COL_W-1:0];
      meta1.row    <= row;
      meta1.last   <= last_px;
    end
  end

  nnps_src_mem #(
    .SOURCE_PIXELS (SOURCE_PIXELS)
  ) u_src_mem (
    .clk   (clk),
    .we    (s_accept && (s_axis_tuser == nnps_pkg::OP_LOAD)),
    .waddr (pix_ext[AW-1:0]),
    .wdata (s_axis_tdata[43:12]),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  nnps_premul u_premul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .in_ready (p_ready),
    .pix      (rdata),
    .meta     (meta1),
    .tvalid   (m_axis_tvalid),
    .tready   (m_axis_tready),
    .tdata    (m_axis_tdata),
    .tlast    (m_axis_tlast)
  );

endmodule

FILE: src/nnps_checker.sv
// port-level checker for the scaler, bound to the top level
`include "assert_macros.svh"

module nnps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [nnps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  logic                               m_accept;
  logic                               m_stall;
  logic                               m_mid;
  logic                               m_end;
  logic [nnps_pkg::COL_W-1:0]         m_col;
  logic [nnps_pkg::ROW_W-1:0]         m_row;
  logic [nnps_pkg::OUT_DATA_W:0]      m_word;
  logic [nnps_pkg::COL_W-1:0]         col_next;
  logic [nnps_pkg::ROW_W-1:0]         row_held;
  logic                               in_seq;

  assign m_accept = m_axis_tvalid && m_axis_tready;
  assign m_stall  = m_axis_tvalid && !m_axis_tready;
  assign m_mid    = m_accept && !m_axis_tlast;
  assign m_end    = m_accept && m_axis_tlast;
  assign m_col    = m_axis_tdata[29:24];
  assign m_row    = m_axis_tdata[41:30];
  assign m_word   = {m_axis_tlast, m_axis_tdata};
  assign in_seq   = (m_col == col_next) && (m_row == row_held);

  // column and row that the next transaction of the same row must carry
  always_ff @(posedge clk) begin
    if (m_accept) begin
      col_next <= m_col + nnps_pkg::COL_W'(1);
      row_held <= m_row;
    end
  end

  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !m_axis_tvalid, "output valid right after reset")

  `ASSERT_CLKD(a_stall_hold, clk, rst, m_stall |=> m_axis_tvalid && $stable(m_word), "stall moved")

  `ASSERT_CLKD(a_row_start, clk, rst, m_end |=> !m_axis_tvalid || m_col == '0, "row start not 0")

  `ASSERT_CLKD(a_col_step, clk, rst, m_mid |=> !m_axis_tvalid || in_seq, "column sequence broken")

endmodule

bind nearest_neighbour_premultiply_scaler_top nnps_checker u_nnps_checker (.*);
